// File: hw/rtl/rvm_pkg.sv
`default_nettype none

package rvm_pkg;

	// operation codes of the func field
	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_RENDER = 2'd1;
	localparam logic [1:0] FUNC_START  = 2'd2;
	localparam logic [1:0] FUNC_FADE   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_STEP            = 3'd0;
	localparam logic [2:0] REG_CLIP_FRAMES     = 3'd1;
	localparam logic [2:0] REG_MODE            = 3'd2;
	localparam logic [2:0] REG_GAIN_LEFT       = 3'd3;
	localparam logic [2:0] REG_GAIN_RIGHT      = 3'd4;
	localparam logic [2:0] REG_FADE_IN_RATE    = 3'd5;
	localparam logic [2:0] REG_FADE_OUT_FRAMES = 3'd6;
	localparam logic [2:0] REG_FADE_OUT_RATE   = 3'd7;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// 1.0 in Q1.24
	localparam logic [24:0] ENV_ONE = 25'h1000000;

	typedef struct packed {
		logic [1:0]         func;
		logic [16:0]        sample_index;
		logic signed [15:0] sample_value;
		logic signed [23:0] acc_left;
		logic signed [23:0] acc_right;
	} req_item_t;

	typedef struct packed {
		logic signed [23:0] mix_left;
		logic signed [23:0] mix_right;
		logic               voice_active;
		logic               saturated;
	} rsp_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/rvm_mul.sv
`default_nettype none

module rvm_mul
	import rvm_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0]      p_q
);

	// registered signed product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

`default_nettype wire

// File: hw/rtl/rvm_clip_mem.sv
`default_nettype none

module rvm_clip_mem #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [15:0]   wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic [15:0]        rd_data_q
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/resampling_voice_mixer.sv
// channel  | direction | valid      | stall      | payload
// ---------+-----------+------------+------------+-----------------------
// request  | in        | req_valid  | req_stall  | req (req_item_t)
// response | out       | rsp_valid  | rsp_stall  | rsp (rsp_item_t)
// config   | in        | cfg_we     | -          | cfg_index, cfg_wdata
//
// Load, start, fade and idle-voice renders go from idle straight to the output state.
// An active render fetches 2 words mono or 4 stereo through one clip memory read
// port, then makes ten passes through the shared multiplier.
// Reset clears control and config; the clip memory holds garbage until loaded.
// A new request is taken while the previous response still waits on a stall;
// the sequencer parks in its output state until the response register frees.

`default_nettype none

module resampling_voice_mixer
	import rvm_pkg::*;
#(
	parameter int MAX_FRAMES = 65536
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire req_item_t              req,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output rsp_item_t                   rsp,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int CLIP_WORDS = 2 * MAX_FRAMES;
	localparam int AW         = $clog2(CLIP_WORDS);
	// integer part of the Q17.16 cursor
	localparam int CUR_INT_W  = 17;
	localparam int CUR_W      = CUR_INT_W + 16;
	// width for the clip end compare
	localparam int LW         = ($clog2(MAX_FRAMES) + 2 > CUR_INT_W + 2) ?
		$clog2(MAX_FRAMES) + 2 : CUR_INT_W + 2;
	// width for the load address range check
	localparam int XW         = ((AW > 17) ? AW : 17) + 1;
	localparam int RAW        = (AW > CUR_INT_W + 2) ? AW : CUR_INT_W + 2;
	localparam int FIH_W      = CUR_INT_W + 24;
	localparam int CON_W      = 19;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_RDW  = 4'd2;
	localparam logic [3:0] S_M1   = 4'd3;
	localparam logic [3:0] S_M2   = 4'd4;
	localparam logic [3:0] S_M3   = 4'd5;
	localparam logic [3:0] S_M4   = 4'd6;
	localparam logic [3:0] S_M5   = 4'd7;
	localparam logic [3:0] S_M6   = 4'd8;
	localparam logic [3:0] S_M7   = 4'd9;
	localparam logic [3:0] S_M8   = 4'd10;
	localparam logic [3:0] S_M9   = 4'd11;
	localparam logic [3:0] S_M10  = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	// configuration
	logic [23:0] step_q;
	logic [16:0] clip_frames_q;
	logic [1:0]  mode_q;
	logic [15:0] gain_left_q;
	logic [15:0] gain_right_q;
	logic [23:0] fade_in_rate_q;
	logic [19:0] fade_out_frames_q;
	logic [23:0] fade_out_rate_q;

	// voice state
	logic [CUR_W-1:0] cursor_q;
	logic             active_q;
	logic [19:0]      fade_rem_q;

	// sequencer
	logic [3:0] state_q;
	logic [1:0] rd_cnt_q;
	logic       rd_vld_s1;
	logic [1:0] rd_slot_s1;
	logic       rd_both_s1;

	// datapath registers
	logic [15:0]      a_l_q, b_l_q, a_r_q, b_r_q;
	logic [15:0]      s_l_q, s_r_q;
	logic [24:0]      fo_q;
	logic [FIH_W-1:0] fi_hi_q;
	logic [24:0]      env_q;
	logic [32:0]      gl_q, gr_q;
	logic [CON_W-1:0] cl_q;
	logic [23:0]      mix_l_q, mix_r_q;
	logic             sat_q;

	rsp_item_t rsp_q;
	logic      rsp_valid_q;

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] p_q;

	// memory
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata_q;

	logic                 req_accept;
	logic                 stereo, looping;
	logic [CUR_INT_W-1:0] cur_hi;
	logic [15:0]          cur_lo;
	logic [LW-1:0]        clip_ext, frames_eff, i_next;
	logic                 at_end;
	logic [XW-1:0]        ld_idx;
	logic                 ld_in_range;
	logic [RAW-1:0]       rd_addr_full;
	logic                 rd_last;
	logic [16:0]          dl, dr;
	logic [33:0]          ip_round;
	logic [17:0]          ip_q18;
	logic [17:0]          ip_sum;
	logic [24:0]          fo_clamp;
	logic [FIH_W:0]       fi_sum;
	logic [24:0]          env_fi;
	logic [MUL_P_W-1:0]   r38;
	logic [CON_W-1:0]     cr;
	logic                 fade_act;
	logic [23:0]          step_eff;
	logic [24:0]          sum_l, sum_r;
	logic                 ovf_l, ovf_r;
	logic [23:0]          sat_l, sat_r;
	logic                 out_load;

	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign stereo  = mode_q[0];
	assign looping = mode_q[1];
	assign cur_hi  = cursor_q[CUR_W-1:16];
	assign cur_lo  = cursor_q[15:0];

	// clip end check: frame count capped at MAX_FRAMES
	assign clip_ext   = LW'(clip_frames_q);
	assign frames_eff = (clip_ext > LW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : clip_ext;
	assign i_next     = LW'(cur_hi) + LW'(1);
	assign at_end     = (i_next >= frames_eff);

	assign ld_idx      = XW'(req.sample_index);
	assign ld_in_range = (ld_idx < XW'(CLIP_WORDS));

	assign mem_we    = req_accept && (req.func == FUNC_LOAD) && ld_in_range;
	assign mem_waddr = ld_idx[AW-1:0];

	// stereo frames interleave L,R so the four words sit at 2i..2i+3
	assign rd_addr_full = stereo ? (RAW'({cur_hi, 1'b0}) + RAW'(rd_cnt_q)) :
		(RAW'(cur_hi) + RAW'(rd_cnt_q));
	assign mem_raddr    = rd_addr_full[AW-1:0];
	assign rd_last      = stereo ? (rd_cnt_q == 2'd3) : (rd_cnt_q == 2'd1);

	rvm_clip_mem #(
		.DEPTH (CLIP_WORDS),
		.AW    (AW)
	) u_clip_mem (
		.clk       (clk),
		.wr_en     (mem_we),
		.wr_addr   (mem_waddr),
		.wr_data   (req.sample_value),
		.rd_addr   (mem_raddr),
		.rd_data_q (mem_rdata_q)
	);

	rvm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// product post-processing
	assign dl       = {b_l_q[15], b_l_q} - {a_l_q[15], a_l_q};
	assign dr       = {b_r_q[15], b_r_q} - {a_r_q[15], a_r_q};
	// interpolation: a + round((b - a) * frac / 2^16), the left or right a
	// is picked by the state that consumes it
	assign ip_round = p_q[33:0] + 34'h8000;
	assign ip_q18   = ip_round[33:16];
	assign ip_sum   = ip_q18 + ((state_q == S_M2) ? {{2{a_l_q[15]}}, a_l_q} :
		{{2{a_r_q[15]}}, a_r_q});

	assign fo_clamp = (p_q[43:0] > 44'(ENV_ONE)) ? ENV_ONE : p_q[24:0];
	assign fi_sum   = (FIH_W+1)'(fi_hi_q) + (FIH_W+1)'(p_q[39:16]);
	assign env_fi   = (fade_in_rate_q == 24'd0) ? ENV_ONE :
		((fi_sum > (FIH_W+1)'(ENV_ONE)) ? ENV_ONE : fi_sum[24:0]);

	// contribution = round(s * gain * env / 2^38)
	assign r38 = MUL_P_W'(p_q) + (MUL_P_W'(1) << 37);
	assign cr  = r38[56:38];

	assign fade_act = (fade_rem_q != 20'd0) && (fade_out_frames_q != 20'd0);
	assign step_eff = (step_q == 24'd0) ? 24'd1 : step_q;

	// saturating accumulate
	assign sum_l = {mix_l_q[23], mix_l_q} + {{(25-CON_W){cl_q[CON_W-1]}}, cl_q};
	assign sum_r = {mix_r_q[23], mix_r_q} + {{(25-CON_W){cr[CON_W-1]}}, cr};
	assign ovf_l = sum_l[24] != sum_l[23];
	assign ovf_r = sum_r[24] != sum_r[23];
	assign sat_l = ovf_l ? (sum_l[24] ? 24'h800000 : 24'h7FFFFF) : sum_l[23:0];
	assign sat_r = ovf_r ? (sum_r[24] ? 24'h800000 : 24'h7FFFFF) : sum_r[23:0];

	assign out_load = (state_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	// operand select for the shared multiplier, one product per state
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M1: begin
				mul_a = {{(MUL_A_W-17){dl[16]}}, dl};
				mul_b = MUL_B_W'(cur_lo);
			end
			S_M2: begin
				mul_a = {{(MUL_A_W-17){dr[16]}}, dr};
				mul_b = MUL_B_W'(cur_lo);
			end
			S_M3: begin
				mul_a = MUL_A_W'(fade_rem_q);
				mul_b = MUL_B_W'(fade_out_rate_q);
			end
			S_M4: begin
				mul_a = MUL_A_W'(cur_hi);
				mul_b = MUL_B_W'(fade_in_rate_q);
			end
			S_M5: begin
				mul_a = MUL_A_W'(cur_lo);
				mul_b = MUL_B_W'(fade_in_rate_q);
			end
			S_M6: begin
				mul_a = {{(MUL_A_W-16){s_l_q[15]}}, s_l_q};
				mul_b = MUL_B_W'(gain_left_q);
			end
			S_M7: begin
				mul_a = MUL_A_W'(env_q);
				mul_b = MUL_B_W'(fo_q);
			end
			S_M8: begin
				mul_a = {{(MUL_A_W-16){s_r_q[15]}}, s_r_q};
				mul_b = MUL_B_W'(gain_right_q);
			end
			S_M9: begin
				mul_a = gl_q;
				mul_b = MUL_B_W'(env_q);
			end
			S_M10: begin
				mul_a = gr_q;
				mul_b = MUL_B_W'(env_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q            <= 24'd65536;
			clip_frames_q     <= '0;
			mode_q            <= '0;
			gain_left_q       <= 16'd16384;
			gain_right_q      <= 16'd16384;
			fade_in_rate_q    <= '0;
			fade_out_frames_q <= '0;
			fade_out_rate_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP:            step_q            <= cfg_wdata;
				REG_CLIP_FRAMES:     clip_frames_q     <= cfg_wdata[16:0];
				REG_MODE:            mode_q            <= cfg_wdata[1:0];
				REG_GAIN_LEFT:       gain_left_q       <= cfg_wdata[15:0];
				REG_GAIN_RIGHT:      gain_right_q      <= cfg_wdata[15:0];
				REG_FADE_IN_RATE:    fade_in_rate_q    <= cfg_wdata;
				REG_FADE_OUT_FRAMES: fade_out_frames_q <= cfg_wdata[19:0];
				REG_FADE_OUT_RATE:   fade_out_rate_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			cursor_q    <= '0;
			active_q    <= 1'b0;
			fade_rem_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_RD);

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						state_q  <= S_OUT;
						rd_cnt_q <= '0;
						case (req.func)
							FUNC_START: begin
								cursor_q   <= '0;
								fade_rem_q <= '0;
								active_q   <= 1'b1;
							end
							FUNC_FADE: begin
								if (active_q) begin
									if (fade_out_frames_q == 20'd0) begin
										active_q   <= 1'b0;
										fade_rem_q <= '0;
									end else begin
										fade_rem_q <= fade_out_frames_q;
									end
								end
							end
							FUNC_RENDER: begin
								if (active_q && (frames_eff != '0)) begin
									if (!at_end) begin
										state_q <= S_RD;
									end else if (looping) begin
										cursor_q <= '0;
										state_q  <= S_RD;
									end else begin
										// one-shot clip ran out
										fade_rem_q <= '0;
										active_q   <= 1'b0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_last) begin
						state_q <= S_RDW;
					end
				end
				S_RDW: state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_M4;
				S_M4:  state_q <= S_M5;
				S_M5:  state_q <= S_M6;
				S_M6:  state_q <= S_M7;
				S_M7:  state_q <= S_M8;
				S_M8:  state_q <= S_M9;
				S_M9:  state_q <= S_M10;
				S_M10: state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_OUT;
					if (fade_act) begin
						fade_rem_q <= fade_rem_q - 20'd1;
					end
					if (fade_act && (fade_rem_q == 20'd1)) begin
						// fade-out finished: silent frame, cursor holds
						active_q <= 1'b0;
					end else begin
						cursor_q <= cursor_q + CUR_W'(step_eff);
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			rd_slot_s1 <= stereo ? rd_cnt_q : {rd_cnt_q[0], 1'b0};
			rd_both_s1 <= !stereo;
		end

		// mono words land in both channels
		if (rd_vld_s1) begin
			case (rd_slot_s1)
				2'd0: begin
					a_l_q <= mem_rdata_q;
					if (rd_both_s1) begin
						a_r_q <= mem_rdata_q;
					end
				end
				2'd1: a_r_q <= mem_rdata_q;
				2'd2: begin
					b_l_q <= mem_rdata_q;
					if (rd_both_s1) begin
						b_r_q <= mem_rdata_q;
					end
				end
				2'd3: b_r_q <= mem_rdata_q;
				default: ;
			endcase
		end

		case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					mix_l_q <= req.acc_left;
					mix_r_q <= req.acc_right;
					sat_q   <= 1'b0;
				end
			end
			S_M2:  s_l_q   <= ip_sum[15:0];
			S_M3:  s_r_q   <= ip_sum[15:0];
			S_M4:  fo_q    <= fo_clamp;
			S_M5:  fi_hi_q <= p_q[FIH_W-1:0];
			S_M6:  env_q   <= env_fi;
			S_M7:  gl_q    <= p_q[32:0];
			S_M8: begin
				if (fade_act) begin
					env_q <= p_q[48:24];
				end
			end
			S_M9:  gr_q    <= p_q[32:0];
			S_M10: cl_q    <= r38[56:38];
			S_FIN: begin
				if (!(fade_act && (fade_rem_q == 20'd1))) begin
					mix_l_q <= sat_l;
					mix_r_q <= sat_r;
					sat_q   <= ovf_l || ovf_r;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			rsp_q.mix_left     <= mix_l_q;
			rsp_q.mix_right    <= mix_r_q;
			rsp_q.voice_active <= active_q;
			rsp_q.saturated    <= sat_q;
		end
	end

endmodule

`default_nettype wire
